/* design/first_occurrence_binary_search_top_assert.svh */
// Assertion macros used by the datapath.
`ifndef FIRST_OCCURRENCE_BINARY_SEARCH_TOP_ASSERT_SVH
`define FIRST_OCCURRENCE_BINARY_SEARCH_TOP_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define FOBS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("fobs: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define FOBS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fobs: implication violated");

`endif

/* design/fobs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fobs_pkg;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CMP,
    ST_PREV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic write_en;
    logic load;
    logic probe;
    logic go_left;
    logic go_right;
    logic read_prev;
    logic set_found;
    logic deliver;
  } fobs_cmd_t;

  typedef struct packed {
    logic range_open;
    logic v_gt;
    logic v_lt;
    logic mid_zero;
    logic prev_eq;
    logic out_pending;
  } fobs_status_t;

endpackage

`default_nettype wire

/* design/fobs_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "first_occurrence_binary_search_top_assert.svh"

module fobs_dpath #(
  parameter int DEPTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fobs_pkg::fobs_cmd_t    cmd,
  input  logic [10:0]            length,
  input  logic [9:0]             in_entry_index,
  input  logic signed [31:0]     in_word,
  input  logic                   out_stall,
  output fobs_pkg::fobs_status_t status,
  output logic                   out_valid,
  output logic                   out_found,
  output logic [9:0]             out_position
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 11) ? CW : 11;

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rd_data_r;
  logic signed [31:0] key_r;
  logic [CW-1:0]      lo_r, hi_ex_r;
  logic [AW-1:0]      mid_r;
  logic               found_r;
  logic [AW-1:0]      pos_r;
  logic               out_valid_r, out_found_r;
  logic [AW-1:0]      out_pos_r;

  logic [LW-1:0] length_ext, n_ext;
  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          idx_ok;

  assign length_ext = LW'(length);
  assign n_ext      = (length_ext > LW'(DEPTH)) ? LW'(DEPTH) : length_ext;

  // floor((low + high) / 2) with high kept as an exclusive bound
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_ex_r} - (CW + 1)'(1);
  assign mid     = mid_sum[AW:1];

  assign rd_en   = cmd.probe | cmd.read_prev;
  assign rd_addr = cmd.read_prev ? (mid_r - AW'(1)) : mid;
  assign idx_ok  = (32'(in_entry_index) < 32'(DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.write_en && idx_ok) begin
      mem[AW'(in_entry_index)] <= in_word;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r    <= '0;
      hi_ex_r <= '0;
      mid_r   <= '0;
      found_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      if (cmd.load) begin
        lo_r    <= '0;
        hi_ex_r <= n_ext[CW-1:0];
        found_r <= 1'b0;
        pos_r   <= '0;
      end
      if (cmd.probe) begin
        mid_r <= mid;
      end
      if (cmd.go_left) begin
        hi_ex_r <= CW'(mid_r);
      end
      if (cmd.go_right) begin
        lo_r <= CW'(mid_r) + CW'(1);
      end
      if (cmd.set_found) begin
        found_r <= 1'b1;
        pos_r   <= mid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
      out_pos_r   <= '0;
    end else if (cmd.deliver) begin
      out_valid_r <= 1'b1;
      out_found_r <= found_r;
      out_pos_r   <= pos_r;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    status.range_open  = (lo_r < hi_ex_r);
    status.v_gt        = ($signed(rd_data_r) > key_r);
    status.v_lt        = ($signed(rd_data_r) < key_r);
    status.mid_zero    = (mid_r == '0);
    status.prev_eq     = ($signed(rd_data_r) == key_r);
    status.out_pending = out_valid_r & out_stall;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = 10'(out_pos_r);

  `FOBS_ASSERT_ALWAYS(a_range_ordered, clk, rst_n, lo_r <= hi_ex_r)
  `FOBS_ASSERT_ALWAYS(a_bound_in_store, clk, rst_n, hi_ex_r <= CW'(DEPTH))
  `FOBS_ASSERT_IMPLIES(a_miss_pos_zero, clk, rst_n, out_valid_r && !out_found_r, out_pos_r == '0)

endmodule

`default_nettype wire

/* design/fobs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module fobs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_command,
  output logic                   in_stall,
  input  fobs_pkg::fobs_status_t status,
  output fobs_pkg::fobs_cmd_t    cmd
);

  fobs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fobs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fobs_pkg::ST_IDLE: begin
        if (in_valid && (in_command == fobs_pkg::CMD_SEARCH)) begin
          state_nxt = fobs_pkg::ST_CHECK;
        end
      end
      fobs_pkg::ST_CHECK: begin
        state_nxt = status.range_open ? fobs_pkg::ST_CMP : fobs_pkg::ST_FINISH;
      end
      fobs_pkg::ST_CMP: begin
        if (status.v_gt || status.v_lt) begin
          state_nxt = fobs_pkg::ST_CHECK;
        end else if (status.mid_zero) begin
          state_nxt = fobs_pkg::ST_FINISH;
        end else begin
          state_nxt = fobs_pkg::ST_PREV;
        end
      end
      fobs_pkg::ST_PREV: begin
        state_nxt = status.prev_eq ? fobs_pkg::ST_CHECK : fobs_pkg::ST_FINISH;
      end
      fobs_pkg::ST_FINISH: begin
        if (!status.out_pending) begin
          state_nxt = fobs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fobs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      fobs_pkg::ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.write_en = in_valid && (in_command == fobs_pkg::CMD_WRITE);
        cmd.load     = in_valid && (in_command == fobs_pkg::CMD_SEARCH);
      end
      fobs_pkg::ST_CHECK: begin
        cmd.probe = status.range_open;
      end
      fobs_pkg::ST_CMP: begin
        if (status.v_gt) begin
          cmd.go_left = 1'b1;
        end else if (status.v_lt) begin
          cmd.go_right = 1'b1;
        end else if (status.mid_zero) begin
          cmd.set_found = 1'b1;
        end else begin
          cmd.read_prev = 1'b1;
        end
      end
      fobs_pkg::ST_PREV: begin
        // equal neighbour on the left: keep searching the left half
        cmd.go_left   = status.prev_eq;
        cmd.set_found = !status.prev_eq;
      end
      fobs_pkg::ST_FINISH: begin
        cmd.deliver = !status.out_pending;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/first_occurrence_binary_search_top.sv */
// First-occurrence binary search over a store of DEPTH signed 32-bit words kept in
// ascending order. A write request (command 0) stores word at entry_index and gives
// no result; indexes at or beyond DEPTH are dropped. A search request (command 1)
// looks for word among entries 0 .. min(length, DEPTH)-1 and returns one result:
// found, and the index of the first occurrence (0 when not found). Each probe is one
// read of the single-port store (check, then compare) plus one more read of the left
// neighbour when the probe matches at a nonzero index, over up to log2(DEPTH)+1
// probes; a search finishes only once a stalled earlier result is taken, and one
// request is in flight at a time. Entries never written read as undefined. The
// length register is decoded at APB addresses 0 to 3 (paddr[2] low).
`timescale 1ns / 1ps
`default_nettype none

module first_occurrence_binary_search_top #(
  parameter int DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [9:0]         in_entry_index,
  input  logic signed [31:0] in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic [9:0]         out_position,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [10:0] length_r, length_nxt;
  logic        length_wr;

  fobs_pkg::fobs_cmd_t    cmd;
  fobs_pkg::fobs_status_t status;

  assign pready    = 1'b1;
  assign length_wr = psel & penable & pwrite & ~paddr[2];
  assign length_nxt = length_wr ? pwdata[10:0] : length_r;
  assign prdata    = paddr[2] ? 32'd0 : 32'(length_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= '0;
    end else begin
      length_r <= length_nxt;
    end
  end

  fobs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  fobs_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .length         (length_r),
    .in_entry_index (in_entry_index),
    .in_word        (in_word),
    .out_stall      (out_stall),
    .status         (status),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_position   (out_position)
  );

endmodule

`default_nettype wire

/* sim/fobs_result_checker.sv */
`timescale 1ns / 1ps

module fobs_result_checker #(
  parameter logic [2:0] LENGTH_ADDR = 3'd0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_command,
  input  logic [9:0]         in_entry_index,
  input  logic signed [31:0] in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_found,
  input  logic [9:0]         out_position,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 outstanding
);

  localparam int STORE_DEPTH = 1024;

  typedef struct packed {
    logic       found;
    logic [9:0] position;
  } lookup_t;

  logic signed [31:0] shadow_store [STORE_DEPTH];
  logic [10:0]        search_len;
  lookup_t            pending_lookups [$];

  // Binary search that keeps heading left while the neighbour below still matches.
  function automatic lookup_t locate_first(input logic signed [31:0] key);
    lookup_t hit;
    int lo;
    int hi;
    int mid;
    int span;
    hit  = '0;
    span = (int'(search_len) > STORE_DEPTH) ? STORE_DEPTH : int'(search_len);
    lo   = 0;
    hi   = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (shadow_store[mid] > key) begin
        hi = mid - 1;
      end else if (shadow_store[mid] < key) begin
        lo = mid + 1;
      end else if (mid == 0 || shadow_store[mid - 1] != shadow_store[mid]) begin
        hit.found    = 1'b1;
        hit.position = 10'(mid);
        lo           = hi + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return hit;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    if (!rst_n) begin
      search_len = '0;
      pending_lookups.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == LENGTH_ADDR) search_len = pwdata[10:0];
        end else if (paddr == LENGTH_ADDR && prdata !== {21'd0, search_len}) begin
          mismatches++;
          $display("%0t: length readback mismatch, expected %0d, got %0d",
                   $time, search_len, prdata);
        end
      end

      if (out_valid && !out_stall) begin
        if (pending_lookups.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got found %0b position %0d",
                   $time, out_found, out_position);
        end else begin
          want = pending_lookups.pop_front();
          if (out_found !== want.found) begin
            mismatches++;
            $display("%0t: found mismatch, expected %0b, got %0b",
                     $time, want.found, out_found);
          end
          if (out_position !== want.position) begin
            mismatches++;
            $display("%0t: position mismatch, expected %0d, got %0d",
                     $time, want.position, out_position);
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (in_command == fobs_pkg::CMD_WRITE) begin
          shadow_store[in_entry_index] = in_word;
        end else begin
          pending_lookups.push_back(locate_first(in_word));
        end
      end
    end
    outstanding = pending_lookups.size();
  end

endmodule

/* sim/tb_first_occurrence_binary_search_top.sv */
`timescale 1ns / 1ps

module tb_first_occurrence_binary_search_top;

  localparam logic [2:0]         ADDR_LENGTH = 3'd0;
  localparam logic [2:0]         ADDR_SPARE  = 3'd4;
  localparam logic signed [31:0] WORD_MIN    = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX    = 32'sh7FFF_FFFF;
  localparam longint             WORD_CEIL   = 64'sd2147483647;
  localparam int                 DRAIN_WAIT  = 40;
  localparam int                 STUCK_LIMIT = 3000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_command;
  logic [9:0]         in_entry_index;
  logic signed [31:0] in_word;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_found;
  logic [9:0]         out_position;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int                 mismatches;
  int                 outstanding;
  int                 cyc = 0;
  int                 stuck = 0;
  int                 sent = 0;
  logic signed [31:0] phase_words [1024];

  wire quiet = (cyc >= 1000 && cyc < 3500);

  always #5 clk = ~clk;

  first_occurrence_binary_search_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_entry_index(in_entry_index),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_position  (out_position),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  fobs_result_checker #(.LENGTH_ADDR(ADDR_LENGTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_entry_index(in_entry_index),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_position  (out_position),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always @(posedge clk) begin
    cyc       <= cyc + 1;
    out_stall <= !quiet && ($urandom_range(0, 99) < 17);
  end

  // nothing moving on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("tb_first_occurrence_binary_search_top NOT OK");
      $finish;
    end
  end

  task automatic send_request(input logic cmd, input logic [9:0] idx,
                              input logic signed [31:0] w);
    while (!quiet && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_entry_index <= idx;
    in_word        <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic search_key(input logic signed [31:0] key);
    send_request(fobs_pkg::CMD_SEARCH, 10'($urandom), key);
  endtask

  // lets any search still in the block finish before the bus is touched
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_length(input logic [31:0] value);
    wait_drained();
    cfg_access(1'b1, ADDR_LENGTH, value);
    cfg_access(1'b0, ADDR_LENGTH, 32'd0);
  endtask

  // ascending run with plenty of duplicates, saturating at the top word
  task automatic lay_sorted(input int n);
    longint v;
    int     r;
    int     idx;
    logic   desc;
    r = $urandom_range(0, 99);
    if (r < 25) v = longint'($signed($urandom));
    else if (r < 35) v = longint'(WORD_MIN);
    else v = longint'($urandom_range(0, 2000)) - 1000;
    for (int i = 0; i < n; i++) begin
      phase_words[i] = v[31:0];
      r = $urandom_range(0, 99);
      if (r < 40) v = v;
      else if (r < 70) v = v + $urandom_range(1, 3);
      else if (r < 90) v = v + $urandom_range(1, 1000);
      else v = v + longint'($urandom_range(0, 32'h7FFF_FFFF));
      if (v > WORD_CEIL) v = WORD_CEIL;
    end
    desc = 1'($urandom_range(0, 1));
    for (int j = 0; j < n; j++) begin
      idx = desc ? n - 1 - j : j;
      send_request(fobs_pkg::CMD_WRITE, 10'(idx), phase_words[idx]);
    end
  endtask

  function automatic logic signed [31:0] pick_key(input int span);
    int                 r;
    logic signed [31:0] k;
    r = $urandom_range(0, 99);
    k = $signed($urandom);
    if (span > 0) begin
      if (r < 55) k = phase_words[$urandom_range(0, span - 1)];
      else if (r < 70) k = phase_words[$urandom_range(0, span - 1)] - 1;
      else if (r < 80) k = phase_words[$urandom_range(0, span - 1)] + 1;
    end
    if (r >= 88 && r < 94) k = WORD_MIN;
    else if (r >= 94) k = WORD_MAX;
    return k;
  endfunction

  task automatic run_phase(input int len_val, input int n_search, input bit refill);
    int                 span;
    int                 r;
    int                 idx;
    logic signed [31:0] w;
    span = (len_val > 1024) ? 1024 : len_val;
    set_length(32'(len_val));
    if (refill) lay_sorted(span);
    for (int s = 0; s < n_search; s++) begin
      r = $urandom_range(0, 99);
      if (r < 9 && span < 1024) begin
        // outside the searched range, harmless
        send_request(fobs_pkg::CMD_WRITE, 10'($urandom_range(span, 1023)),
                     $signed($urandom));
      end else if (r < 12 && span > 0) begin
        // breaks the ordering
        idx = $urandom_range(0, span - 1);
        w   = $signed($urandom);
        phase_words[idx] = w;
        send_request(fobs_pkg::CMD_WRITE, 10'(idx), w);
      end else begin
        search_key(pick_key(span));
      end
    end
  endtask

  initial begin
    int  r;
    int  n;
    bit  big_done;
    big_done       = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= fobs_pkg::CMD_WRITE;
    in_entry_index <= '0;
    in_word        <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // length zero straight out of reset
    search_key(32'sd0);
    search_key(WORD_MIN);
    search_key(WORD_MAX);
    // unknown register must leave length alone
    wait_drained();
    cfg_access(1'b1, ADDR_SPARE, 32'd5);
    search_key(32'sd0);

    // single entry, extreme words and top index
    send_request(fobs_pkg::CMD_WRITE, 10'd0, WORD_MIN);
    send_request(fobs_pkg::CMD_WRITE, 10'h3FF, WORD_MAX);
    set_length(32'd1);
    search_key(WORD_MIN);
    search_key(WORD_MAX);
    search_key(32'sd0);

    // duplicate runs, first occurrence to the left of the first probe
    send_request(fobs_pkg::CMD_WRITE, 10'd0, WORD_MIN);
    send_request(fobs_pkg::CMD_WRITE, 10'd1, WORD_MIN);
    send_request(fobs_pkg::CMD_WRITE, 10'd2, -32'sd1);
    send_request(fobs_pkg::CMD_WRITE, 10'd3, 32'sd7);
    send_request(fobs_pkg::CMD_WRITE, 10'd4, 32'sd7);
    send_request(fobs_pkg::CMD_WRITE, 10'd5, 32'sd7);
    set_length(32'd6);
    search_key(WORD_MIN);
    search_key(32'sd7);
    search_key(-32'sd1);
    search_key(32'sd6);
    search_key(32'sd8);

    // descending store, length written with upper bus bits set
    send_request(fobs_pkg::CMD_WRITE, 10'd0, 32'sd9);
    send_request(fobs_pkg::CMD_WRITE, 10'd1, 32'sd5);
    send_request(fobs_pkg::CMD_WRITE, 10'd2, 32'sd3);
    set_length(32'hFFFF_F803);
    search_key(32'sd5);
    search_key(32'sd9);

    while (sent < 1300 || !big_done) begin
      if (!big_done && sent >= 60) begin
        run_phase(1024, 40, 1'b1);
        run_phase(1023, 20, 1'b0);
        run_phase(1025, 20, 1'b0);
        run_phase(2047, 20, 1'b0);
        big_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) n = 0;
        else if (r < 12) n = 1;
        else if (r < 16) n = 2;
        else n = $urandom_range(3, 48);
        if (big_done && r >= 97) run_phase(1024, 20, 1'b0);
        else run_phase(n, $urandom_range(n / 2 + 3, 2 * n + 6), 1'b1);
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("tb_first_occurrence_binary_search_top OK");
    end else begin
      $display("tb_first_occurrence_binary_search_top NOT OK");
    end
    $finish;
  end

endmodule
